[hdl/hbd_pkg.sv]
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants of the two-wheel h-bridge drive
// Request kinds, duty actions, per-wheel pin state and pipeline enables.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int PERIOD_W = 17;
  localparam int DT_W     = 8;
  localparam int PCT_W    = 16;
  localparam int TIME_W   = 32;
  localparam int MAG_W    = 7;
  localparam int PROD_W   = 24;
  localparam int RECIP_W  = 26;
  localparam int T_W      = PROD_W + RECIP_W;
  localparam int CFG_A_W  = 1;

  localparam logic signed [PCT_W-1:0] PCT_LIMIT = 16'sd100;
  localparam logic [PROD_W-1:0]       DIV_K     = 24'd100;
  // floor(2^32 / 100), quotient estimate is exact or one short
  localparam logic [RECIP_W-1:0]      RECIP     = 26'd42949672;
  localparam int                      RECIP_SH  = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd1000;
  localparam logic [DT_W-1:0]     DT_RST     = 8'd1;

  localparam logic [CFG_A_W-1:0] CFG_PWM_PERIOD = 1'b0;
  localparam logic [CFG_A_W-1:0] CFG_DEAD_TIME  = 1'b1;

  typedef enum logic [1:0] {
    REQ_BOTH  = 2'd0,
    REQ_LEFT  = 2'd1,
    REQ_RIGHT = 2'd2,
    REQ_BRAKE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DUTY_KEEP = 2'd0,
    DUTY_ZERO = 2'd1,
    DUTY_FULL = 2'd2,
    DUTY_CALC = 2'd3
  } duty_op_t;

  typedef struct packed {
    logic              fwd;
    logic              rev;
    logic signed [1:0] dir_rpt;
  } wheel_ctrl_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_en_t;

endpackage

[hdl/hbd_wheel.sv]
// ----------------------------------------------------------------------------
// hbd_wheel: direction and dead-time control of one wheel
// Holds the wheel's direction state and neutral interval, updates it on each
// accepted beat that addresses the wheel and tells the duty lane what to do
// with the compare value.
module hbd_wheel (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take_drive,
  input  logic                                 take_brake,
  input  logic signed [hbd_pkg::PCT_W-1:0]     pct,
  input  logic        [hbd_pkg::TIME_W-1:0]    now_ms,
  input  logic        [hbd_pkg::DT_W-1:0]      dead_time_ms,
  output hbd_pkg::wheel_ctrl_t                 ctrl_next,
  output hbd_pkg::duty_op_t                    op,
  output logic        [hbd_pkg::MAG_W-1:0]     mag
);

  logic signed [1:0]                 held_dir, held_dir_next;
  logic                              pending, pending_next;
  logic                              started, started_next;
  logic [hbd_pkg::TIME_W-1:0]        start_time, start_time_next;
  hbd_pkg::wheel_ctrl_t              ctrl, ctrl_sel;

  logic signed [hbd_pkg::PCT_W-1:0]  clamped;
  logic signed [hbd_pkg::PCT_W-1:0]  abs_pct;
  logic signed [1:0]                 dir;
  logic [hbd_pkg::TIME_W-1:0]        elapsed;

  always_comb begin
    if (pct > hbd_pkg::PCT_LIMIT) begin
      clamped = hbd_pkg::PCT_LIMIT;
    end else if (pct < -hbd_pkg::PCT_LIMIT) begin
      clamped = -hbd_pkg::PCT_LIMIT;
    end else begin
      clamped = pct;
    end
    abs_pct = clamped[hbd_pkg::PCT_W-1] ? -clamped : clamped;
    mag     = abs_pct[hbd_pkg::MAG_W-1:0];
    if (clamped[hbd_pkg::PCT_W-1]) begin
      dir = -2'sd1;
    end else if (clamped != '0) begin
      dir = 2'sd1;
    end else begin
      dir = 2'sd0;
    end
    elapsed = now_ms - start_time;
  end

  always_comb begin
    held_dir_next    = held_dir;
    pending_next     = pending;
    started_next     = started;
    start_time_next  = start_time;
    ctrl_sel         = ctrl;
    op               = hbd_pkg::DUTY_KEEP;
    if (take_brake) begin
      ctrl_sel.fwd     = 1'b0;
      ctrl_sel.rev     = 1'b0;
      held_dir_next    = 2'sd0;
      pending_next     = 1'b1;
      started_next     = 1'b0;
      op               = hbd_pkg::DUTY_FULL;
    end else if (take_drive) begin
      // neutral unless the command can be applied
      ctrl_sel.fwd     = 1'b0;
      ctrl_sel.rev     = 1'b0;
      held_dir_next    = 2'sd0;
      op               = hbd_pkg::DUTY_ZERO;
      if (dir == 2'sd0 || (pending && !started)) begin
        if (pending && !started) begin
          started_next    = 1'b1;
          start_time_next = now_ms;
        end
      end else if (pending && elapsed < {{(hbd_pkg::TIME_W-hbd_pkg::DT_W){1'b0}},
                                         dead_time_ms}) begin
        // still inside the dead time
      end else if (held_dir != 2'sd0 && dir != held_dir) begin
        // reversal opens a neutral interval now
        pending_next    = 1'b1;
        started_next    = 1'b1;
        start_time_next = now_ms;
      end else begin
        pending_next     = 1'b0;
        started_next     = 1'b0;
        ctrl_sel.fwd     = (dir == 2'sd1);
        ctrl_sel.rev     = (dir == -2'sd1);
        ctrl_sel.dir_rpt = dir;
        held_dir_next    = dir;
        op               = hbd_pkg::DUTY_CALC;
      end
    end
    ctrl_next = ctrl_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_dir     <= 2'sd0;
      pending      <= 1'b0;
      started      <= 1'b0;
      start_time   <= '0;
      ctrl.fwd     <= 1'b0;
      ctrl.rev     <= 1'b0;
      ctrl.dir_rpt <= 2'sd1;
    end else begin
      held_dir    <= held_dir_next;
      pending     <= pending_next;
      started     <= started_next;
      start_time  <= start_time_next;
      ctrl        <= ctrl_sel;
    end
  end

endmodule

[hdl/hbd_duty.sv]
// ----------------------------------------------------------------------------
// hbd_duty: duty arithmetic lane of one wheel
// period * magnitude, then division by 100 through a reciprocal multiply and
// a single remainder correction, over three registered stages.
// ----------------------------------------------------------------------------
module hbd_duty (
  input  logic                                clk,
  input  hbd_pkg::pipe_en_t                   en,
  input  hbd_pkg::duty_op_t                   op,
  input  logic [hbd_pkg::PERIOD_W-1:0]        period,
  input  logic [hbd_pkg::MAG_W-1:0]           mag,
  output logic                                keep,
  output logic [hbd_pkg::PERIOD_W-1:0]        duty
);

  hbd_pkg::duty_op_t               op1, op2, op3;
  logic [hbd_pkg::PERIOD_W-1:0]    per1, per2, per3;
  logic [hbd_pkg::MAG_W-1:0]       mag1;
  logic [hbd_pkg::PROD_W-1:0]      prod2, prod3;
  logic [hbd_pkg::T_W-1:0]         recip3;

  logic [hbd_pkg::PERIOD_W-1:0]    quot_est;
  logic [hbd_pkg::PROD_W-1:0]      rem;
  logic [hbd_pkg::PERIOD_W-1:0]    quot;

  always_ff @(posedge clk) begin
    if (en.en1) begin
      op1  <= op;
      per1 <= period;
      mag1 <= mag;
    end
    if (en.en2) begin
      op2   <= op1;
      per2  <= per1;
      prod2 <= hbd_pkg::PROD_W'(per1) * hbd_pkg::PROD_W'(mag1);
    end
    if (en.en3) begin
      op3    <= op2;
      per3   <= per2;
      prod3  <= prod2;
      recip3 <= hbd_pkg::T_W'(prod2) * hbd_pkg::T_W'(hbd_pkg::RECIP);
    end
  end

  always_comb begin
    quot_est = recip3[hbd_pkg::RECIP_SH +: hbd_pkg::PERIOD_W];
    rem      = prod3 - hbd_pkg::PROD_W'(quot_est * hbd_pkg::DIV_K);
    quot     = (rem >= hbd_pkg::DIV_K) ? quot_est + 1'b1 : quot_est;
    keep     = (op3 == hbd_pkg::DUTY_KEEP);
    case (op3)
      hbd_pkg::DUTY_FULL: duty = per3;
      hbd_pkg::DUTY_CALC: duty = quot;
      default:            duty = '0;
    endcase
  end

endmodule

[hdl/h_bridge_dead_time_drive.sv]
// ----------------------------------------------------------------------------
// h_bridge_dead_time_drive: two-wheel h-bridge drive with dead time
// Speed, single-wheel and brake requests in, pin levels and pwm compare
// values for both wheels out.
// ----------------------------------------------------------------------------
// One beat is taken every clock cycle unless the output holds back the stages,
// and each request's result beat passes four registers (three duty stages
// and the output register) before it is offered. Direction, dead-time and pin
// state of each wheel are updated in the cycle the request is taken; the
// compare value then runs through two multiply stages (period times speed,
// reciprocal of 100) and a remainder correction in each wheel's duty lane
// before it is merged into the output register. A wheel that a request does
// not address keeps its last compare value and pins. Registers: index 0 pwm
// period in ticks (reset 1000), index 1 dead time in ms (reset 1); write them
// only while idle.
module h_bridge_dead_time_drive (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_cmd [15:0], right_cmd [31:16], now_ms [63:32]
  input  logic [63:0] s_axis_tdata,
  // req_type [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_duty [16:0], left_fwd [17], left_rev [18], left_dir_report [20:19],
  // right_duty [37:21], right_fwd [38], right_rev [39],
  // right_dir_report [41:40], zero [47:42]
  output logic [47:0] m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [hbd_pkg::CFG_A_W-1:0]        cfg_addr,
  input  logic [hbd_pkg::PERIOD_W-1:0]       cfg_wdata
);

  logic [hbd_pkg::PERIOD_W-1:0] pwm_period;
  logic [hbd_pkg::DT_W-1:0]     dead_time_ms;

  hbd_pkg::req_t     req;
  logic              accept;
  logic              take_drive [2];
  logic              take_brake;
  logic signed [hbd_pkg::PCT_W-1:0] pct [2];

  hbd_pkg::wheel_ctrl_t ctrl_next [2];
  hbd_pkg::duty_op_t    op [2];
  logic [hbd_pkg::MAG_W-1:0]    mag [2];
  logic                         keep [2];
  logic [hbd_pkg::PERIOD_W-1:0] duty [2];

  hbd_pkg::wheel_ctrl_t ctrl1 [2];
  hbd_pkg::wheel_ctrl_t ctrl2 [2];
  hbd_pkg::wheel_ctrl_t ctrl3 [2];
  hbd_pkg::wheel_ctrl_t out_ctrl [2];
  logic [hbd_pkg::PERIOD_W-1:0] out_duty [2];
  logic v1, v2, v3, out_valid;
  logic en_out;
  hbd_pkg::pipe_en_t en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period   <= hbd_pkg::PERIOD_RST;
      dead_time_ms <= hbd_pkg::DT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hbd_pkg::CFG_PWM_PERIOD: pwm_period   <= cfg_wdata;
        hbd_pkg::CFG_DEAD_TIME:  dead_time_ms <= cfg_wdata[hbd_pkg::DT_W-1:0];
      endcase
    end
  end

  // stage enables, a bubble lets the stage behind it move
  always_comb begin
    en_out = !out_valid || m_axis_tready;
    en.en3 = !v3 || en_out;
    en.en2 = !v2 || en.en3;
    en.en1 = !v1 || en.en2;
  end

  // no beat is taken while in reset
  assign s_axis_tready = en.en1 && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = hbd_pkg::req_t'(s_axis_tuser);
  assign take_brake    = accept && (req == hbd_pkg::REQ_BRAKE);
  assign take_drive[0] = accept && (req == hbd_pkg::REQ_BOTH || req == hbd_pkg::REQ_LEFT);
  assign take_drive[1] = accept && (req == hbd_pkg::REQ_BOTH || req == hbd_pkg::REQ_RIGHT);
  assign pct[0]        = s_axis_tdata[15:0];
  assign pct[1]        = s_axis_tdata[31:16];

  for (genvar w = 0; w < 2; w++) begin : g_lane
    hbd_wheel u_wheel (
      .clk          (clk),
      .rst          (rst),
      .take_drive   (take_drive[w]),
      .take_brake   (take_brake),
      .pct          (pct[w]),
      .now_ms       (s_axis_tdata[63:32]),
      .dead_time_ms (dead_time_ms),
      .ctrl_next    (ctrl_next[w]),
      .op           (op[w]),
      .mag          (mag[w])
    );

    hbd_duty u_duty (
      .clk    (clk),
      .en     (en),
      .op     (op[w]),
      .period (pwm_period),
      .mag    (mag[w]),
      .keep   (keep[w]),
      .duty   (duty[w])
    );

    always_ff @(posedge clk) begin
      if (en.en1) ctrl1[w] <= ctrl_next[w];
      if (en.en2) ctrl2[w] <= ctrl1[w];
      if (en.en3) ctrl3[w] <= ctrl2[w];
    end

    // merge: an unaddressed wheel keeps the compare value last sent
    always_ff @(posedge clk) begin
      if (rst) begin
        out_duty[w]         <= '0;
        out_ctrl[w].fwd     <= 1'b0;
        out_ctrl[w].rev     <= 1'b0;
        out_ctrl[w].dir_rpt <= 2'sd1;
      end else if (en_out && v3) begin
        out_ctrl[w] <= ctrl3[w];
        if (!keep[w]) out_duty[w] <= duty[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.en1) v1 <= s_axis_tvalid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
      if (en_out) out_valid <= v3;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0,
                          out_ctrl[1].dir_rpt, out_ctrl[1].rev, out_ctrl[1].fwd, out_duty[1],
                          out_ctrl[0].dir_rpt, out_ctrl[0].rev, out_ctrl[0].fwd, out_duty[0]};

`ifndef ASSERT_OFF
  // both bridge inputs of a wheel are never driven together
  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    !(out_ctrl[0].fwd && out_ctrl[0].rev) && !(out_ctrl[1].fwd && out_ctrl[1].rev))
    else $error("bridge forward and reverse high together");

  // a brake leaves both wheels with all pins low
  a_brake_neutral: assert property (@(posedge clk) disable iff (rst)
    take_brake |=> (!ctrl1[0].fwd && !ctrl1[0].rev && !ctrl1[1].fwd && !ctrl1[1].rev))
    else $error("brake beat left a bridge pin high");

  // a computed left duty always comes with exactly one left pin driven
  a_calc_has_dir: assert property (@(posedge clk) disable iff (rst)
    (accept && op[0] == hbd_pkg::DUTY_CALC) |-> (ctrl_next[0].fwd ^ ctrl_next[0].rev))
    else $error("left duty applied without a direction");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the two-wheel h-bridge drive
// Sends speed, single-wheel and brake requests and keeps its own model of
// both wheels (dead time, neutral, clamp, duty). Each output beat is compared
// field by field against that model. Both handshakes idle at random, the
// output is held off for a long stretch and the registers run through
// several settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 12;

  // one wheel as the bench tracks it
  typedef struct packed {
    logic signed [1:0]              applied;
    logic                           pending;
    logic                           started;
    logic [hbd_pkg::TIME_W-1:0]     t0;
    logic signed [1:0]              report;
    logic [hbd_pkg::PERIOD_W-1:0]   duty;
    logic                           fwd;
    logic                           rev;
  } wheel_state_t;

  // output beat, lowest field last
  typedef struct packed {
    logic [5:0]                     pad;
    logic signed [1:0]              r_dir;
    logic                           r_rev;
    logic                           r_fwd;
    logic [hbd_pkg::PERIOD_W-1:0]   r_duty;
    logic signed [1:0]              l_dir;
    logic                           l_rev;
    logic                           l_fwd;
    logic [hbd_pkg::PERIOD_W-1:0]   l_duty;
  } drive_out_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [63:0]                  s_axis_tdata = '0;
  logic [1:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [47:0]                  m_axis_tdata;
  logic                         cfg_we = 1'b0;
  logic [hbd_pkg::CFG_A_W-1:0]  cfg_addr = '0;
  logic [hbd_pkg::PERIOD_W-1:0] cfg_wdata = '0;

  wheel_state_t                 wheel_st [2];
  logic [hbd_pkg::PERIOD_W-1:0] period_reg;
  logic [hbd_pkg::DT_W-1:0]     dead_reg;
  drive_out_t                   drive_expect [$];
  drive_out_t                   mon_got;
  drive_out_t                   mon_want;
  int                           mismatches = 0;
  bit                           idle_on = 1'b1;
  int                           hold_budget = 0;

  always #2 clk = ~clk;

  h_bridge_dead_time_drive u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  // ------------------------------------------------------------------ model

  function automatic int limit_cmd(logic [hbd_pkg::PCT_W-1:0] raw);
    int p;
    p = $signed(raw);
    if (p > 100) p = 100;
    if (p < -100) p = -100;
    return p;
  endfunction

  function automatic void neutral_wheel(inout wheel_state_t w);
    w.duty    = '0;
    w.fwd     = 1'b0;
    w.rev     = 1'b0;
    w.applied = 2'sd0;
  endfunction

  function automatic void steer_wheel(inout wheel_state_t w, input int pct,
                                      input logic [hbd_pkg::TIME_W-1:0] now);
    logic signed [1:0] dir;
    logic [31:0]       mag;
    logic [31:0]       elapsed;
    dir = (pct > 0) ? 2'sd1 : ((pct < 0) ? -2'sd1 : 2'sd0);
    if (dir == 2'sd0) begin
      neutral_wheel(w);
      if (w.pending && !w.started) begin
        w.started = 1'b1;
        w.t0      = now;
      end
      return;
    end
    if (w.pending) begin
      // interval left open by a brake starts here
      if (!w.started) begin
        neutral_wheel(w);
        w.started = 1'b1;
        w.t0      = now;
        return;
      end
      elapsed = now - w.t0;
      if (elapsed < {24'd0, dead_reg}) begin
        neutral_wheel(w);
        return;
      end
      w.pending = 1'b0;
      w.started = 1'b0;
    end
    if (w.applied != 2'sd0 && dir != w.applied) begin
      neutral_wheel(w);
      w.pending = 1'b1;
      w.started = 1'b1;
      w.t0      = now;
      return;
    end
    if (w.applied != dir) begin
      neutral_wheel(w);
      w.fwd = (dir > 0);
      w.rev = (dir < 0);
    end
    mag       = (pct > 0) ? pct : -pct;
    w.duty    = hbd_pkg::PERIOD_W'(({15'd0, period_reg} * mag) / 32'd100);
    w.applied = dir;
    w.report  = dir;
  endfunction

  function automatic drive_out_t predict_drive(hbd_pkg::req_t kind,
                                               logic [hbd_pkg::PCT_W-1:0] lraw,
                                               logic [hbd_pkg::PCT_W-1:0] rraw,
                                               logic [hbd_pkg::TIME_W-1:0] now);
    drive_out_t o;
    wheel_state_t w0, w1;
    w0 = wheel_st[0];
    w1 = wheel_st[1];
    case (kind)
      hbd_pkg::REQ_BOTH: begin
        steer_wheel(w0, limit_cmd(lraw), now);
        steer_wheel(w1, limit_cmd(rraw), now);
      end
      hbd_pkg::REQ_LEFT:  steer_wheel(w0, limit_cmd(lraw), now);
      hbd_pkg::REQ_RIGHT: steer_wheel(w1, limit_cmd(rraw), now);
      default: begin
        neutral_wheel(w0);
        neutral_wheel(w1);
        w0.duty    = period_reg;
        w1.duty    = period_reg;
        w0.pending = 1'b1;
        w1.pending = 1'b1;
        w0.started = 1'b0;
        w1.started = 1'b0;
      end
    endcase
    wheel_st[0] = w0;
    wheel_st[1] = w1;
    o        = '0;
    o.l_duty = w0.duty;
    o.l_fwd  = w0.fwd;
    o.l_rev  = w0.rev;
    o.l_dir  = w0.report;
    o.r_duty = w1.duty;
    o.r_fwd  = w1.fwd;
    o.r_rev  = w1.rev;
    o.r_dir  = w1.report;
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_req(hbd_pkg::req_t kind, logic [hbd_pkg::PCT_W-1:0] lp,
                          logic [hbd_pkg::PCT_W-1:0] rp,
                          logic [hbd_pkg::TIME_W-1:0] now);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, rp, lp};
    s_axis_tuser  <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    drive_expect.push_back(predict_drive(kind, lp, rp, now));
  endtask

  // drop valid and wait until every result beat is back
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (drive_expect.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [hbd_pkg::CFG_A_W-1:0] idx,
                           logic [hbd_pkg::PERIOD_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == hbd_pkg::CFG_PWM_PERIOD) period_reg = val;
    else dead_reg = val[hbd_pkg::DT_W-1:0];
  endtask

  function automatic logic [hbd_pkg::PCT_W-1:0] rand_pct();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 20) return ($urandom_range(0, 1) != 0) ? 16'sd100 : -16'sd100;
    if (r < 35) return hbd_pkg::PCT_W'($urandom);
    if (r < 45) return hbd_pkg::PCT_W'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 3)
                                                                    : -$urandom_range(1, 3));
    return hbd_pkg::PCT_W'(int'($urandom_range(0, 200)) - 100);
  endfunction

  // -------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_budget > 0) begin
      m_axis_tready <= 1'b0;
      hold_budget = hold_budget - 1;
    end else if (idle_on && $urandom_range(0, 99) < 36) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got = m_axis_tdata;
      if (drive_expect.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat %h with nothing expected", $realtime, m_axis_tdata);
        mismatches++;
      end else begin
        mon_want = drive_expect.pop_front();
        if (mon_got.l_duty !== mon_want.l_duty || mon_got.l_fwd !== mon_want.l_fwd ||
            mon_got.l_rev !== mon_want.l_rev || mon_got.l_dir !== mon_want.l_dir ||
            mon_got.r_duty !== mon_want.r_duty || mon_got.r_fwd !== mon_want.r_fwd ||
            mon_got.r_rev !== mon_want.r_rev || mon_got.r_dir !== mon_want.r_dir ||
            mon_got.pad !== mon_want.pad) begin
          if (mismatches < 10) begin
            $display("%0t: left  duty/fwd/rev/dir exp %0d/%b/%b/%0d got %0d/%b/%b/%0d",
                     $realtime, mon_want.l_duty, mon_want.l_fwd, mon_want.l_rev,
                     mon_want.l_dir, mon_got.l_duty, mon_got.l_fwd, mon_got.l_rev,
                     mon_got.l_dir);
            $display("%0t: right duty/fwd/rev/dir exp %0d/%b/%b/%0d got %0d/%b/%b/%0d",
                     $realtime, mon_want.r_duty, mon_want.r_fwd, mon_want.r_rev,
                     mon_want.r_dir, mon_got.r_duty, mon_got.r_fwd, mon_got.r_rev,
                     mon_got.r_dir);
            $display("%0t: pad got %h", $realtime, mon_got.pad);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ------------------------------------------------------------------ tests

  // reset values: period 1000, dead time 1
  task automatic test_directed_defaults();
    send_req(hbd_pkg::REQ_BOTH,  16'sd50,    -16'sd50,   32'd10);
    send_req(hbd_pkg::REQ_BOTH,  16'h7FFF,   16'h8000,   32'd11);   // clamp both ways
    send_req(hbd_pkg::REQ_BOTH,  -16'sd1,    16'sd1,     32'd12);   // reversal, go neutral
    send_req(hbd_pkg::REQ_BOTH,  -16'sd1,    16'sd1,     32'd12);   // dead time not yet over
    send_req(hbd_pkg::REQ_BOTH,  -16'sd101,  16'sd101,   32'd13);
    send_req(hbd_pkg::REQ_LEFT,  16'sd0,     16'sd7,     32'd14);   // right field ignored
    send_req(hbd_pkg::REQ_RIGHT, 16'sd99,    16'sd0,     32'd15);   // left field ignored
    send_req(hbd_pkg::REQ_BRAKE, 16'h7FFF,   16'h8000,   32'd16);
    send_req(hbd_pkg::REQ_LEFT,  16'sd0,     16'sd0,     32'd20);   // zero starts interval
    send_req(hbd_pkg::REQ_LEFT,  16'sd30,    16'sd0,     32'd20);
    send_req(hbd_pkg::REQ_LEFT,  16'sd30,    16'sd0,     32'd21);
    send_req(hbd_pkg::REQ_RIGHT, 16'sd0,     16'sd1,     32'd22);   // brake left it open
    send_req(hbd_pkg::REQ_RIGHT, 16'sd0,     16'sd1,     32'd23);
    send_req(hbd_pkg::REQ_BOTH,  16'sd100,   -16'sd100,  32'd24);
  endtask

  task automatic test_zero_dead_time();
    write_reg(hbd_pkg::CFG_DEAD_TIME, 17'd0);
    write_reg(hbd_pkg::CFG_PWM_PERIOD, 17'd65536);
    send_req(hbd_pkg::REQ_BRAKE, 16'sd0,     16'sd0,     32'd100);
    send_req(hbd_pkg::REQ_BOTH,  16'sd100,   16'sd100,   32'd100);
    send_req(hbd_pkg::REQ_BOTH,  16'sd100,   16'sd100,   32'd100);
    send_req(hbd_pkg::REQ_BOTH,  -16'sd100,  -16'sd3,    32'd100);
    send_req(hbd_pkg::REQ_BOTH,  -16'sd100,  -16'sd3,    32'd100);
  endtask

  task automatic test_period_extremes();
    write_reg(hbd_pkg::CFG_PWM_PERIOD, 17'd0);
    write_reg(hbd_pkg::CFG_DEAD_TIME, 17'h1FFFF);                   // dead time 255
    send_req(hbd_pkg::REQ_BRAKE, 16'sd5,     16'sd5,     32'hFFFF_FFF0);
    send_req(hbd_pkg::REQ_BOTH,  16'sd5,     -16'sd5,    32'hFFFF_FFF0);
    send_req(hbd_pkg::REQ_BOTH,  16'sd5,     -16'sd5,    32'h0000_00EE);   // wrapped, 254 ms
    send_req(hbd_pkg::REQ_BOTH,  16'sd5,     -16'sd5,    32'h0000_00EF);   // wrapped, 255 ms
    write_reg(hbd_pkg::CFG_PWM_PERIOD, 17'h1FFFF);
    send_req(hbd_pkg::REQ_BOTH,  16'sd100,   16'sd37,    32'h0000_0100);
    send_req(hbd_pkg::REQ_BRAKE, 16'sd0,     16'sd0,     32'h0000_0101);
  endtask

  task automatic run_random(int count, int step_max);
    logic [hbd_pkg::TIME_W-1:0] t;
    int r;
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 5) t = $urandom;
      else if (r < 85) t = t + $urandom_range(0, step_max);
      r = $urandom_range(0, 99);
      send_req((r < 35) ? hbd_pkg::REQ_BOTH : (r < 60) ? hbd_pkg::REQ_LEFT :
               (r < 88) ? hbd_pkg::REQ_RIGHT : hbd_pkg::REQ_BRAKE,
               rand_pct(), rand_pct(), t);
    end
  endtask

  task automatic test_random_settings();
    logic [hbd_pkg::PERIOD_W-1:0] periods [6];
    logic [hbd_pkg::DT_W-1:0]     deads   [6];
    periods = '{17'd1000, 17'd1, 17'd65536, 17'h1FFFF, 17'd0, 17'd1000};
    deads   = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd17, 8'd1};
    periods[5] = hbd_pkg::PERIOD_W'($urandom_range(2, 131071));
    deads[5]   = hbd_pkg::DT_W'($urandom_range(0, 255));
    for (int i = 0; i < 6; i++) begin
      write_reg(hbd_pkg::CFG_PWM_PERIOD, periods[i]);
      write_reg(hbd_pkg::CFG_DEAD_TIME, {9'($urandom_range(0, 511)), deads[i]});
      run_random(180, deads[i] + 3);
    end
  endtask

  // output held off while requests keep coming, so the input must stall
  task automatic test_output_stall();
    write_reg(hbd_pkg::CFG_PWM_PERIOD, 17'd1000);
    write_reg(hbd_pkg::CFG_DEAD_TIME, 17'd2);
    hold_budget = LONG_HOLD;
    run_random(60, 5);
  endtask

  task automatic test_back_to_back();
    settle();
    idle_on = 1'b0;
    run_random(120, 3);
    idle_on = 1'b1;
  endtask

  initial begin
    wheel_st[0] = '{applied: 2'sd0, pending: 1'b0, started: 1'b0, t0: '0,
                    report: 2'sd1, duty: '0, fwd: 1'b0, rev: 1'b0};
    wheel_st[1] = wheel_st[0];
    period_reg  = hbd_pkg::PERIOD_RST;
    dead_reg    = hbd_pkg::DT_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_zero_dead_time();
    test_period_extremes();
    test_random_settings();
    test_output_stall();
    test_back_to_back();

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && drive_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
